// ----- rtl/rdau_pkg.sv -----
// Shared constants, codes and state types of the radix digit arithmetic unit.
package rdau_pkg;

	localparam int IN_DIGITS  = 9;
	localparam int OUT_DIGITS = 18;
	localparam int OPND_W     = 30;
	localparam int VAL_W      = 30;
	localparam int RES_W      = 60;
	localparam int DIGIT_W    = 4;
	localparam int BCD_W      = IN_DIGITS * DIGIT_W;
	localparam int DIG_W      = OUT_DIGITS * DIGIT_W;
	localparam int SHORT_BITS = VAL_W + 1;

	localparam logic [3:0] BASE_RESET = 4'd10;
	localparam logic [3:0] BASE_MIN   = 4'd2;
	localparam logic [3:0] BASE_MAX   = 4'd10;

	localparam logic [2:0] ACT_ADD = 3'd0;
	localparam logic [2:0] ACT_SUB = 3'd1;
	localparam logic [2:0] ACT_DIV = 3'd2;
	localparam logic [2:0] ACT_MOD = 3'd3;
	localparam logic [2:0] ACT_MUL = 3'd4;

	typedef enum logic [1:0] {
		OP_IDLE,
		OP_DABBLE,
		OP_HORNER
	} opc_state_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ALU,
		ST_SETUP,
		ST_CONV,
		ST_PACK,
		ST_FINISH
	} rdau_state_t;

endpackage

// ----- rtl/radix_digit_arithmetic_unit_top.sv -----
// Top level: operand conversion, arithmetic (serial divide/multiply) and base-b result formatting.
//
// Channel   Ports                                          Transfer
// config    cfg_we, cfg_wdata                              edge with cfg_we high
// command   start, busy, operand_a, operand_b, action      edge with start high, busy low
// result    done, result_digits, negative_flag,            edge ending the done cycle
//           divide_by_zero, overflow_flag
//
// Accept to done: the operands pass the converters (30 BCD shifts plus 9 Horner steps),
// then the one-bit-a-cycle divide/multiply (not for add/subtract), the base-b shift and
// the decimal packing; a result forced to zero skips every step after the converters.
// busy is low again in the cycle done is shown. Reset puts number_base at ten and
// the controller at idle. The receiver cannot stall; each result shows for one cycle.
module radix_digit_arithmetic_unit_top
	import rdau_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [3:0]        cfg_wdata,
	input  logic              start,
	output logic              busy,
	input  logic [OPND_W-1:0] operand_a,
	input  logic [OPND_W-1:0] operand_b,
	input  logic [2:0]        action,
	output logic              done,
	output logic [RES_W-1:0]  result_digits,
	output logic              negative_flag,
	output logic              divide_by_zero,
	output logic              overflow_flag
);

	localparam int CNT_W = $clog2(RES_W + 1);

	rdau_state_t       state_q, state_d;
	logic [3:0]        number_base_q;
	logic [3:0]        base_q, base_eff;
	logic [2:0]        act_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [RES_W-1:0]  work_q;
	logic [VAL_W-1:0]  rem_q;
	logic [DIG_W-1:0]  dig_q;
	logic              zero_q, neg_q, dz_q, ovf_q;
	logic [RES_W-1:0]  result_q;
	logic              neg_out_q, dz_out_q, ovf_out_q, done_q;

	logic              conv_start;
	logic [VAL_W-1:0]  a_val, c_val;
	logic              a_done, c_done;
	logic              sub_neg, div_zero, is_mul;
	logic              alu_last, conv_last, pack_last;
	rdau_state_t       load_dest;

	// divide / multiply step
	logic [VAL_W:0]    mul_sum, div_trial;
	logic              div_ge;

	// base-b doubling step
	logic [OUT_DIGITS-1:0] dg_gen, dg_prop, dg_x;
	logic [OUT_DIGITS:0]   dg_sum, dg_carry;
	logic [DIG_W-1:0]      dig_next;
	logic [4:0]            dbl;

	// decimal packing step
	logic [3:0]        pack_digit;
	logic [RES_W-1:0]  pack_acc;

	always_comb begin
		priority if (number_base_q < BASE_MIN) base_eff = BASE_MIN;
		else if (number_base_q > BASE_MAX)     base_eff = BASE_MAX;
		else                                   base_eff = number_base_q;
	end

	rdau_opnd_conv u_conv_a (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (conv_start),
		.operand (operand_a),
		.base    (base_eff),
		.value   (a_val),
		.done    (a_done)
	);

	rdau_opnd_conv u_conv_b (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (conv_start),
		.operand (operand_b),
		.base    (base_eff),
		.value   (c_val),
		.done    (c_done)
	);

	assign sub_neg  = (a_val < c_val);
	assign div_zero = (c_val == '0);
	assign is_mul   = (act_q == ACT_MUL);

	assign alu_last  = (cnt_q == CNT_W'(VAL_W - 1));
	assign conv_last = is_mul ? (cnt_q == CNT_W'(RES_W - 1)) : (cnt_q == CNT_W'(SHORT_BITS - 1));
	assign pack_last = (cnt_q == CNT_W'(OUT_DIGITS - 1));

	always_comb begin
		unique case (act_q)
			ACT_ADD:          load_dest = ST_SETUP;
			ACT_SUB:          load_dest = sub_neg ? ST_FINISH : ST_SETUP;
			ACT_DIV, ACT_MOD: load_dest = div_zero ? ST_FINISH : ST_ALU;
			ACT_MUL:          load_dest = ST_ALU;
			default:          load_dest = ST_FINISH;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (start) state_d = ST_LOAD;
			ST_LOAD:   if (a_done && c_done) state_d = load_dest;
			ST_ALU:    if (alu_last) state_d = ST_SETUP;
			ST_SETUP:  state_d = ST_CONV;
			ST_CONV:   if (conv_last) state_d = ST_PACK;
			ST_PACK:   if (pack_last) state_d = ST_FINISH;
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy       = (state_q != ST_IDLE);
		conv_start = (state_q == ST_IDLE) && start;
	end

	// shift-add multiply and restoring divide share work_q
	assign mul_sum   = {1'b0, work_q[RES_W-1:VAL_W]} + (work_q[0] ? {1'b0, c_val} : '0);
	assign div_trial = {rem_q, work_q[VAL_W-1]};
	assign div_ge    = (div_trial >= {1'b0, c_val});

	// base-b digits times two plus the incoming bit; carries via generate/propagate add
	always_comb begin
		for (int i = 0; i < OUT_DIGITS; i++) begin
			dbl        = {dig_q[i*DIGIT_W +: DIGIT_W], 1'b0};
			dg_gen[i]  = (dbl >= {1'b0, base_q});
			dg_prop[i] = ({dbl[4:1], 1'b1} == {1'b0, base_q});
		end
		dg_x     = dg_gen | dg_prop;
		dg_sum   = {1'b0, dg_x} + {1'b0, dg_gen} + (OUT_DIGITS+1)'(work_q[RES_W-1]);
		dg_carry = dg_sum ^ {1'b0, dg_x} ^ {1'b0, dg_gen};
		for (int i = 0; i < OUT_DIGITS; i++) begin
			dbl = 5'({dig_q[i*DIGIT_W +: DIGIT_W], 1'b0}) + 5'(dg_carry[i])
				- (dg_carry[i+1] ? {1'b0, base_q} : 5'd0);
			dig_next[i*DIGIT_W +: DIGIT_W] = dbl[3:0];
		end
	end

	assign pack_digit = ovf_q ? (base_q - 4'd1) : dig_q[DIG_W-1 -: DIGIT_W];
	assign pack_acc   = {work_q[RES_W-4:0], 3'b000} + {work_q[RES_W-2:0], 1'b0}
		+ RES_W'(pack_digit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			number_base_q <= BASE_RESET;
			cnt_q         <= '0;
			done_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_FINISH);
			if (cfg_we)
				number_base_q <= cfg_wdata;
			if (state_q == ST_ALU || state_q == ST_CONV || state_q == ST_PACK) begin
				if ((state_q == ST_ALU && alu_last) || (state_q == ST_CONV && conv_last)
					|| (state_q == ST_PACK && pack_last))
					cnt_q <= '0;
				else
					cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					act_q  <= action;
					base_q <= base_eff;
					zero_q <= 1'b0;
					neg_q  <= 1'b0;
					dz_q   <= 1'b0;
					ovf_q  <= 1'b0;
				end
			end
			ST_LOAD: begin
				if (a_done && c_done) begin
					unique case (act_q)
						ACT_ADD: work_q <= RES_W'(SHORT_BITS'(a_val) + SHORT_BITS'(c_val));
						ACT_SUB: begin
							neg_q  <= sub_neg;
							zero_q <= sub_neg;
							work_q <= RES_W'(a_val - c_val);
						end
						ACT_DIV, ACT_MOD: begin
							dz_q   <= div_zero;
							zero_q <= div_zero;
							work_q <= RES_W'(a_val);
							rem_q  <= '0;
						end
						ACT_MUL: work_q <= RES_W'(a_val);
						default: zero_q <= 1'b1;
					endcase
				end
			end
			ST_ALU: begin
				if (is_mul) begin
					work_q <= {mul_sum, work_q[VAL_W-1:1]};
				end else begin
					rem_q <= div_ge ? VAL_W'(div_trial - {1'b0, c_val}) : div_trial[VAL_W-1:0];
					work_q[VAL_W-1:0] <= {work_q[VAL_W-2:0], div_ge};
				end
			end
			ST_SETUP: begin
				dig_q <= '0;
				ovf_q <= 1'b0;
				// short results go out MSB first from the top of the shifter
				if (!is_mul) begin
					if (act_q == ACT_MOD)
						work_q <= {1'b0, rem_q, {(RES_W-SHORT_BITS){1'b0}}};
					else
						work_q <= {work_q[SHORT_BITS-1:0], {(RES_W-SHORT_BITS){1'b0}}};
				end
			end
			ST_CONV: begin
				dig_q <= dig_next;
				ovf_q <= ovf_q | dg_carry[OUT_DIGITS];
				if (conv_last)
					work_q <= '0;
				else
					work_q <= {work_q[RES_W-2:0], 1'b0};
			end
			ST_PACK: begin
				work_q <= pack_acc;
				dig_q  <= {dig_q[DIG_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
			end
			ST_FINISH: begin
				result_q  <= zero_q ? '0 : work_q;
				neg_out_q <= neg_q;
				dz_out_q  <= dz_q;
				ovf_out_q <= ovf_q && !zero_q;
			end
			default: ;
		endcase
	end

	assign done           = done_q;
	assign result_digits  = result_q;
	assign negative_flag  = neg_out_q;
	assign divide_by_zero = dz_out_q;
	assign overflow_flag  = ovf_out_q;

	a_done_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == ST_FINISH)
		else $error("result strobe without a finish cycle");

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("accepted command did not make the unit busy");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $countones({negative_flag, divide_by_zero, overflow_flag}) <= 1)
		else $error("more than one result flag set");

	a_forced_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (negative_flag || divide_by_zero) |-> result_digits == '0)
		else $error("flagged result is not zero");

endmodule

// ----- rtl/rdau_opnd_conv.sv -----
// Operand converter: binary operand to BCD digits bit-serially, then base-b Horner sum.
module rdau_opnd_conv
	import rdau_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [OPND_W-1:0] operand,
	input  logic [3:0]        base,
	output logic [VAL_W-1:0]  value,
	output logic              done
);

	localparam int CNT_W = $clog2(OPND_W);

	opc_state_t        state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [OPND_W-1:0] sh_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [VAL_W-1:0]  val_q;
	logic              done_q;

	logic              dabble_en, horner_en, dabble_last, horner_last;
	logic [BCD_W-1:0]  bcd_adj;
	logic [VAL_W+3:0]  horner_sum;

	assign dabble_last = (cnt_q == CNT_W'(OPND_W - 1));
	assign horner_last = (cnt_q == CNT_W'(IN_DIGITS - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			OP_IDLE:   if (start) state_d = OP_DABBLE;
			OP_DABBLE: if (dabble_last) state_d = OP_HORNER;
			OP_HORNER: if (horner_last) state_d = OP_IDLE;
			default:   state_d = OP_IDLE;
		endcase
	end

	always_comb begin
		dabble_en = (state_q == OP_DABBLE);
		horner_en = (state_q == OP_HORNER);
	end

	// add-3 on every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < IN_DIGITS; i++) begin
			if (bcd_q[i*DIGIT_W +: DIGIT_W] >= 4'd5)
				bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + 4'd3;
			else
				bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
		end
	end

	assign horner_sum = (VAL_W+4)'(val_q) * (VAL_W+4)'(base)
		+ (VAL_W+4)'(bcd_q[BCD_W-1 -: DIGIT_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= OP_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= horner_en && horner_last;
			if (state_q == OP_IDLE || (dabble_en && dabble_last) || horner_en && horner_last)
				cnt_q <= '0;
			else
				cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == OP_IDLE && start) begin
			sh_q  <= operand;
			bcd_q <= '0;
			val_q <= '0;
		end else if (dabble_en) begin
			// digits above the ninth fall off the top
			bcd_q <= {bcd_adj[BCD_W-2:0], sh_q[OPND_W-1]};
			sh_q  <= {sh_q[OPND_W-2:0], 1'b0};
		end else if (horner_en) begin
			val_q <= horner_sum[VAL_W-1:0];
			bcd_q <= {bcd_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
		end
	end

	assign value = val_q;
	assign done  = done_q;

endmodule
